/* rtl/assert_macros.svh */
// Assertion macros for RTL that checks its own behaviour; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at an edge implies consequent at the same edge.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent true at an edge implies consequent at the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mdpt_pkg.sv */
// Package with shared constants and types of the minimum distance thinning block.
package mdpt_pkg;

  localparam int MAX_KEPT_DEF   = 256;
  localparam int COORD_BITS_DEF = 12;
  localparam int DIST_W         = 12;
  localparam int LIM_W          = 2 * DIST_W;
  localparam int SLOT_W         = 8;

  // Control travelling from one cell to its lower neighbour.
  typedef struct packed {
    logic qv;    // query stage holds a transaction's point
    logic done;  // square stage holds a valid result
    logic fail;  // some cell so far found a point too close
  } link_t;

endpackage

/* rtl/min_distance_point_thinning.sv */
// Top level of the minimum distance point thinning block: control and the cell chain.
//
// Points enter one transaction at a time on the input channel (in_valid, in_stall,
// start_set, pos_x, pos_y, pos_z); each gives exactly one result transaction on the
// output channel (out_valid, out_stall, keep, slot, full_drop). The minimum distance
// is written through cfg_valid, cfg_ready and cfg_data, and its square is kept.
// Kept points live in a chain of MAX_KEPT cells, one point per cell. An accepted
// point is injected into the highest occupied cell and walks down one cell per cycle,
// each cell checking the squared distance to its own point, so the verdict leaves
// cell 0 once the point has passed every occupied cell. The verdict is registered,
// and the result is loaded once the output is free; an empty table passes with no
// walk. The time per item is set by the length of the occupied chain and by output
// stalls. The input stalls until the result is loaded and can then take the next point.
// The output is registered, so a finished result may wait while the next point is
// accepted and worked on; the block only holds the following result back, and
// stalls its input, while the receiver keeps stalling.
// Reset empties the table and sets the minimum distance to one; no result is pending.

`include "assert_macros.svh"

module min_distance_point_thinning #(
  parameter int MAX_KEPT   = mdpt_pkg::MAX_KEPT_DEF,
  parameter int COORD_BITS = mdpt_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              start_set,
  input  logic signed [COORD_BITS-1:0]      pos_x,
  input  logic signed [COORD_BITS-1:0]      pos_y,
  input  logic signed [COORD_BITS-1:0]      pos_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              keep,
  output logic [mdpt_pkg::SLOT_W-1:0]       slot,
  output logic                              full_drop,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdpt_pkg::DIST_W-1:0]       cfg_data
);

  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int LIM_W = mdpt_pkg::LIM_W;
  localparam int DIST_W = mdpt_pkg::DIST_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cnt_eff;
  logic [IDX_W-1:0]      inj_idx;
  logic [LIM_W-1:0]      limit;
  logic [COORD_BITS-1:0] hx, hy, hz;
  logic [COORD_BITS-1:0] ld_x, ld_y, ld_z;
  logic                  res_pass;
  logic                  in_acc, fin_go, out_free, full, do_write;

  mdpt_pkg::link_t       link [MAX_KEPT+1];
  logic [COORD_BITS-1:0] cx [MAX_KEPT+1];
  logic [COORD_BITS-1:0] cy [MAX_KEPT+1];
  logic [COORD_BITS-1:0] cz [MAX_KEPT+1];

  // The configuration write is always taken; only the square is needed.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      limit <= {{DIST_W{1'b0}}, cfg_data} * {{DIST_W{1'b0}}, cfg_data};
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_go   = (state == S_FIN) && out_free;
  assign full     = (count == CNT_W'(MAX_KEPT));
  assign do_write = fin_go && res_pass && !full;

  // A start flag empties the table before the point is looked at.
  assign cnt_eff = start_set ? '0 : count;
  assign inj_idx = IDX_W'(cnt_eff - 1'b1);

  // The input coordinates are injected on acceptance; the held copy is written later.
  assign ld_x = (state == S_IDLE) ? pos_x : hx;
  assign ld_y = (state == S_IDLE) ? pos_y : hy;
  assign ld_z = (state == S_IDLE) ? pos_z : hz;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hx <= pos_x;
      hy <= pos_y;
      hz <= pos_z;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (cnt_eff == '0) ? S_FIN : S_RUN;
        end
      end
      S_RUN: begin
        if (link[0].done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        count <= cnt_eff;
      end else if (do_write) begin
        count <= count + 1'b1;
      end
    end
  end

  // An empty table passes at once; otherwise the verdict comes out of cell 0.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_pass <= 1'b1;
    end else if (state == S_RUN && link[0].done) begin
      res_pass <= !link[0].fail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      keep      <= res_pass && !full;
      slot      <= (res_pass && !full) ? mdpt_pkg::SLOT_W'(count) : '0;
      full_drop <= res_pass && full;
    end
  end

  // Nothing lives above the last cell.
  assign link[MAX_KEPT] = '0;
  assign cx[MAX_KEPT]   = '0;
  assign cy[MAX_KEPT]   = '0;
  assign cz[MAX_KEPT]   = '0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    logic inj, wr_en;

    assign inj   = in_acc && (cnt_eff != '0) && (inj_idx == IDX_W'(i));
    assign wr_en = do_write && (count[IDX_W-1:0] == IDX_W'(i));

    mdpt_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .inj      (inj),
      .wr_en    (wr_en),
      .ld_x     (ld_x),
      .ld_y     (ld_y),
      .ld_z     (ld_z),
      .limit    (limit),
      .nbr_link (link[i+1]),
      .nbr_x    (cx[i+1]),
      .nbr_y    (cy[i+1]),
      .nbr_z    (cz[i+1]),
      .link     (link[i]),
      .qx       (cx[i]),
      .qy       (cy[i]),
      .qz       (cz[i])
    );
  end

  // A result never claims both a stored point and a full-table drop.
  `ASSERT_SAME(a_keep_excl, clk, rst, out_valid, !(keep && full_drop))
  // A verdict reaches the bottom of the chain only while a point is being checked.
  `ASSERT_SAME(a_done_in_run, clk, rst, link[0].done, state == S_RUN)
  // An accepted point always leaves the controller busy in the next cycle.
  `ASSERT_NEXT(a_acc_busy, clk, rst, in_acc, state != S_IDLE)

endmodule

/* rtl/mdpt_cell.sv */
// One cell of the comparison chain: a stored point and a two-stage distance check.
module mdpt_cell #(
  parameter int COORD_BITS = mdpt_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       inj,
  input  logic                       wr_en,
  input  logic [COORD_BITS-1:0]      ld_x,
  input  logic [COORD_BITS-1:0]      ld_y,
  input  logic [COORD_BITS-1:0]      ld_z,
  input  logic [mdpt_pkg::LIM_W-1:0] limit,
  input  mdpt_pkg::link_t            nbr_link,
  input  logic [COORD_BITS-1:0]      nbr_x,
  input  logic [COORD_BITS-1:0]      nbr_y,
  input  logic [COORD_BITS-1:0]      nbr_z,
  output mdpt_pkg::link_t            link,
  output logic [COORD_BITS-1:0]      qx,
  output logic [COORD_BITS-1:0]      qy,
  output logic [COORD_BITS-1:0]      qz
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int CMP_W = (SQ_W > mdpt_pkg::LIM_W) ? SQ_W : mdpt_pkg::LIM_W;

  logic [COORD_BITS-1:0] sx, sy, sz;
  logic                  qv;
  logic                  sv, sf;
  logic [SQ_W-1:0]       sqx, sqy, sqz;
  logic [D_W-1:0]        dx, dy, dz;
  logic [D_W-1:0]        mx, my, mz;
  logic [SQ_W-1:0]       sum;
  logic                  lt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sx <= ld_x;
      sy <= ld_y;
      sz <= ld_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else begin
      qv <= inj | nbr_link.qv;
    end
  end

  always_ff @(posedge clk) begin
    qx <= inj ? ld_x : nbr_x;
    qy <= inj ? ld_y : nbr_y;
    qz <= inj ? ld_z : nbr_z;
  end

  assign dx = {qx[COORD_BITS-1], qx} - {sx[COORD_BITS-1], sx};
  assign dy = {qy[COORD_BITS-1], qy} - {sy[COORD_BITS-1], sy};
  assign dz = {qz[COORD_BITS-1], qz} - {sz[COORD_BITS-1], sz};
  assign mx = dx[D_W-1] ? (~dx + 1'b1) : dx;
  assign my = dy[D_W-1] ? (~dy + 1'b1) : dy;
  assign mz = dz[D_W-1] ? (~dz + 1'b1) : dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
      sf <= 1'b0;
    end else begin
      sv <= qv;
      sf <= nbr_link.fail;
    end
  end

  always_ff @(posedge clk) begin
    sqx <= {{D_W{1'b0}}, mx} * {{D_W{1'b0}}, mx};
    sqy <= {{D_W{1'b0}}, my} * {{D_W{1'b0}}, my};
    sqz <= {{D_W{1'b0}}, mz} * {{D_W{1'b0}}, mz};
  end

  assign sum = sqx + sqy + sqz;
  assign lt  = CMP_W'(sum) < CMP_W'(limit);

  assign link.qv   = qv;
  assign link.done = sv;
  assign link.fail = sv & (sf | lt);

endmodule
